@@ hdl/decaying_load_latency_monitor_core_defines.svh @@
// Assertion macros for the checker of the load monitor.
`ifndef DECAYING_LOAD_LATENCY_MONITOR_CORE_DEFINES_SVH
`define DECAYING_LOAD_LATENCY_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, off while rst_n is low.
`define DLLM_AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while rst_n is low.
`define DLLM_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dllm_pkg.sv @@
package dllm_pkg;

  localparam int MODE_W    = 3;
  localparam int SEC_W     = 32;
  localparam int LAT_W     = 20;
  localparam int LAT4_W    = LAT_W + 2;
  localparam int NUM_W     = 16;
  localparam int OUT_W     = 46;
  localparam int TGT_W     = 32;
  localparam int CFG_IDX_W = 1;

  // item modes; the remaining codes only age and query
  localparam logic [MODE_W-1:0] MODE_COUNT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LAT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BOTH  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BATCH = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_AVG  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PEAK = 1'b1;

  // shared mul/div unit operations
  typedef enum logic [1:0] {
    MD_MUL,       // product of operand and multiplier
    MD_DIV_WIDE,  // previous product divided by operand
    MD_DIV_ACC    // accumulator-wide dividend divided by operand
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_sts_t;

endpackage

@@ hdl/dllm_ifs.sv @@
interface dllm_in_if import dllm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SEC_W-1:0]  now_seconds;
  logic [LAT_W-1:0]  latency_ms;
  logic [NUM_W-1:0]  sample_count;

  modport source (output valid, mode, now_seconds, latency_ms, sample_count, input ready);
  modport sink   (input valid, mode, now_seconds, latency_ms, sample_count, output ready);
endinterface

interface dllm_out_if import dllm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] count_rate;
  logic [OUT_W-1:0] avg_latency;
  logic [OUT_W-1:0] peak_latency;
  logic             overloaded;

  modport source (output valid, count_rate, avg_latency, peak_latency, overloaded,
                  input ready);
  modport sink   (input valid, count_rate, avg_latency, peak_latency, overloaded,
                  output ready);
endinterface

@@ hdl/decaying_load_latency_monitor_core.sv @@
// Decaying load and latency monitor. Each beat on in_ch first ages four
// accumulators to now_seconds (one decay round per elapsed second, a full
// clear when time runs backward or more than STALE_SECONDS ahead), records
// the sample or batch, and returns one beat on out_ch with the count rate,
// average and peak latency and the overload flag. One item at a time: ready
// drops for the whole item. After the decay rounds, the item takes two output
// quotients when events are held, a peak multiply in the latency modes and
// for a non-empty batch, and a batch divide when sample_count exceeds one.
// These share the single mul/div adder, which retires one bit per cycle. The
// result sits in an output register, so a new beat is taken while the last
// result waits. Target registers are written through cfg_we/cfg_idx/cfg_wdata
// and should only change while the block is idle.
module decaying_load_latency_monitor_core import dllm_pkg::*; #(
  parameter int STALE_SECONDS = 8,
  parameter int ACC_WIDTH     = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  dllm_in_if.sink              in_ch,
  dllm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [TGT_W-1:0]     cfg_wdata
);

  localparam int PROD_W = ACC_WIDTH + LAT4_W;
  localparam int RND_W  = $clog2(STALE_SECONDS + 1);
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE,      // wait for a beat
    S_AGE,       // one decay round per cycle
    S_REC,       // record count / latency / batch
    S_PK_MUL,    // events * latency, in quarter-ms units
    S_PK_MUL_W,
    S_PK_DIV,    // ... / sample_count for a batch
    S_PK_DIV_W,
    S_PK_UPD,    // raise peak accumulator
    S_CHK,       // any events?
    S_AVG_DIV,   // avg_acc / events
    S_AVG_W,
    S_PKQ_DIV,   // peak_acc / events
    S_PKQ_W,
    S_DONE       // hand result to the output register
  } state_t;

  state_t               state_r, state_nxt;
  logic [SEC_W-1:0]     last_r, last_nxt;
  logic [ACC_WIDTH-1:0] cnt_acc_r, cnt_acc_nxt;
  logic [ACC_WIDTH-1:0] evt_acc_r, evt_acc_nxt;
  logic [ACC_WIDTH-1:0] avg_acc_r, avg_acc_nxt;
  logic [ACC_WIDTH-1:0] pk_acc_r, pk_acc_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [LAT_W-1:0]     lat_r, lat_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt;
  logic [RND_W-1:0]     rnd_r, rnd_nxt;
  logic [ACC_WIDTH-1:0] avg_q_r, avg_q_nxt;
  logic [ACC_WIDTH-1:0] pk_q_r, pk_q_nxt;
  logic [TGT_W-1:0]     tgt_avg_r, tgt_avg_nxt;
  logic [TGT_W-1:0]     tgt_pk_r, tgt_pk_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic [OUT_W-1:0]     out_avg_r, out_avg_nxt;
  logic [OUT_W-1:0]     out_pk_r, out_pk_nxt;
  logic                 out_over_r, out_over_nxt;

  md_cmd_t              md_cmd;
  md_sts_t              md_sts;
  logic [ACC_WIDTH-1:0] md_opnd;
  logic [ACC_WIDTH-1:0] md_dividend;
  logic [PROD_W-1:0]    md_result;

  logic                 in_fire;
  logic [SEC_W:0]       ahead;
  logic                 stale;
  logic                 rec_lat;
  logic [NUM_W-1:0]     evt_inc;
  logic [ACC_WIDTH-1:0] cand;
  logic [ACC_WIDTH-1:0] avg_val, pk_val;
  logic                 over;

  function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] x,
                                                    input logic [LAT_W-1:0] inc);
    logic [ACC_WIDTH:0] s;
    s = {1'b0, x} + (ACC_WIDTH + 1)'(inc);
    return s[ACC_WIDTH] ? ACC_MAX : s[ACC_WIDTH-1:0];
  endfunction

  // lose a quarter, rounded up
  function automatic logic [ACC_WIDTH-1:0] less_q_up(input logic [ACC_WIDTH-1:0] x);
    return x - ((x >> 2) + ACC_WIDTH'(|x[1:0]));
  endfunction

  assign in_fire = in_ch.valid && in_ch.ready;

  // backward time shows up as a borrow out of the 33-bit difference
  assign ahead = {1'b0, in_ch.now_seconds} - {1'b0, last_r};
  assign stale = ahead[SEC_W] || (ahead[SEC_W-1:0] > SEC_W'(STALE_SECONDS));

  assign rec_lat = (mode_r inside {MODE_LAT, MODE_BOTH, MODE_BATCH});
  assign evt_inc = (mode_r == MODE_BATCH) ? num_r : NUM_W'(1);

  // exact candidate, clipped to the accumulator range
  assign cand = (|md_result[PROD_W-1:ACC_WIDTH]) ? ACC_MAX : md_result[ACC_WIDTH-1:0];

  assign avg_val = avg_q_r >> 2;
  assign pk_val  = pk_q_r >> 2;
  assign over    = ((tgt_pk_r != '0) && (pk_val > ACC_WIDTH'(tgt_pk_r))) ||
                   ((tgt_avg_r != '0) && (avg_val > ACC_WIDTH'(tgt_avg_r)));

  // shared unit commands
  always_comb begin
    md_cmd.start = 1'b0;
    md_cmd.op    = MD_MUL;
    case (state_r)
      S_PK_MUL: begin
        md_cmd.start = 1'b1;
        md_cmd.op    = MD_MUL;
      end
      S_PK_DIV: begin
        md_cmd.start = 1'b1;
        md_cmd.op    = MD_DIV_WIDE;
      end
      S_AVG_DIV, S_PKQ_DIV: begin
        md_cmd.start = 1'b1;
        md_cmd.op    = MD_DIV_ACC;
      end
      default: begin
        md_cmd.start = 1'b0;
      end
    endcase
  end

  assign md_opnd     = (state_r == S_PK_DIV) ? ACC_WIDTH'(num_r) : evt_acc_r;
  assign md_dividend = (state_r == S_PKQ_DIV) ? pk_acc_r : avg_acc_r;

  dllm_muldiv #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (md_cmd),
    .sts      (md_sts),
    .opnd     (md_opnd),
    .mplier   ({lat_r, 2'b00}),
    .dividend (md_dividend),
    .result   (md_result)
  );

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    cnt_acc_nxt   = cnt_acc_r;
    evt_acc_nxt   = evt_acc_r;
    avg_acc_nxt   = avg_acc_r;
    pk_acc_nxt    = pk_acc_r;
    mode_nxt      = mode_r;
    lat_nxt       = lat_r;
    num_nxt       = num_r;
    rnd_nxt       = rnd_r;
    avg_q_nxt     = avg_q_r;
    pk_q_nxt      = pk_q_r;
    tgt_avg_nxt   = tgt_avg_r;
    tgt_pk_nxt    = tgt_pk_r;
    out_valid_nxt = out_valid_r;
    out_cnt_nxt   = out_cnt_r;
    out_avg_nxt   = out_avg_r;
    out_pk_nxt    = out_pk_r;
    out_over_nxt  = out_over_r;

    if (cfg_we) begin
      case (cfg_idx)
        CFG_TARGET_AVG:  tgt_avg_nxt = cfg_wdata;
        CFG_TARGET_PEAK: tgt_pk_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mode_nxt = in_ch.mode;
          num_nxt  = in_ch.sample_count;
          // in the single-sample modes the smallest non-zero latency records as zero
          if ((in_ch.mode inside {MODE_LAT, MODE_BOTH}) &&
              (in_ch.latency_ms == LAT_W'(1))) begin
            lat_nxt = '0;
          end else begin
            lat_nxt = in_ch.latency_ms;
          end
          last_nxt = in_ch.now_seconds;
          if (in_ch.now_seconds == last_r) begin
            state_nxt = S_REC;
          end else if (stale) begin
            cnt_acc_nxt = '0;
            evt_acc_nxt = '0;
            avg_acc_nxt = '0;
            pk_acc_nxt  = '0;
            state_nxt   = S_REC;
          end else begin
            rnd_nxt   = ahead[RND_W-1:0];
            state_nxt = S_AGE;
          end
        end
      end
      S_AGE: begin
        cnt_acc_nxt = less_q_up(cnt_acc_r);
        evt_acc_nxt = less_q_up(evt_acc_r);
        avg_acc_nxt = avg_acc_r - (avg_acc_r >> 2);
        pk_acc_nxt  = pk_acc_r - (pk_acc_r >> 2);
        rnd_nxt     = rnd_r - RND_W'(1);
        if (rnd_r == RND_W'(1)) begin
          state_nxt = S_REC;
        end
      end
      S_REC: begin
        if (mode_r inside {MODE_COUNT, MODE_BOTH}) begin
          cnt_acc_nxt = sat_add(cnt_acc_r, LAT_W'(1));
        end else if (mode_r == MODE_BATCH) begin
          cnt_acc_nxt = sat_add(cnt_acc_r, LAT_W'(num_r));
        end
        if (rec_lat) begin
          evt_acc_nxt = sat_add(evt_acc_r, LAT_W'(evt_inc));
          avg_acc_nxt = sat_add(avg_acc_r, lat_r);
          pk_acc_nxt  = sat_add(pk_acc_r, lat_r);
        end
        // empty batch skips the candidate
        if ((mode_r inside {MODE_LAT, MODE_BOTH}) ||
            ((mode_r == MODE_BATCH) && (num_r != '0))) begin
          state_nxt = S_PK_MUL;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_PK_MUL: begin
        state_nxt = S_PK_MUL_W;
      end
      S_PK_MUL_W: begin
        if (md_sts.done) begin
          // a batch of one skips the divide by one
          if ((mode_r == MODE_BATCH) && (num_r != NUM_W'(1))) begin
            state_nxt = S_PK_DIV;
          end else begin
            state_nxt = S_PK_UPD;
          end
        end
      end
      S_PK_DIV: begin
        state_nxt = S_PK_DIV_W;
      end
      S_PK_DIV_W: begin
        if (md_sts.done) begin
          state_nxt = S_PK_UPD;
        end
      end
      S_PK_UPD: begin
        if (pk_acc_r < cand) begin
          pk_acc_nxt = cand;
        end
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (evt_acc_r == '0) begin
          avg_q_nxt = '0;
          pk_q_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_AVG_DIV;
        end
      end
      S_AVG_DIV: begin
        state_nxt = S_AVG_W;
      end
      S_AVG_W: begin
        if (md_sts.done) begin
          avg_q_nxt = md_result[ACC_WIDTH-1:0];
          state_nxt = S_PKQ_DIV;
        end
      end
      S_PKQ_DIV: begin
        state_nxt = S_PKQ_W;
      end
      S_PKQ_W: begin
        if (md_sts.done) begin
          pk_q_nxt  = md_result[ACC_WIDTH-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = OUT_W'(cnt_acc_r >> 2);
          out_avg_nxt   = OUT_W'(avg_val);
          out_pk_nxt    = OUT_W'(pk_val);
          out_over_nxt  = over;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= '0;
      cnt_acc_r   <= '0;
      evt_acc_r   <= '0;
      avg_acc_r   <= '0;
      pk_acc_r    <= '0;
      rnd_r       <= '0;
      tgt_avg_r   <= '0;
      tgt_pk_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      cnt_acc_r   <= cnt_acc_nxt;
      evt_acc_r   <= evt_acc_nxt;
      avg_acc_r   <= avg_acc_nxt;
      pk_acc_r    <= pk_acc_nxt;
      rnd_r       <= rnd_nxt;
      tgt_avg_r   <= tgt_avg_nxt;
      tgt_pk_r    <= tgt_pk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r     <= mode_nxt;
    lat_r      <= lat_nxt;
    num_r      <= num_nxt;
    avg_q_r    <= avg_q_nxt;
    pk_q_r     <= pk_q_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_avg_r  <= out_avg_nxt;
    out_pk_r   <= out_pk_nxt;
    out_over_r <= out_over_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE) && !md_sts.busy;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.count_rate   = out_cnt_r;
  assign out_ch.avg_latency  = out_avg_r;
  assign out_ch.peak_latency = out_pk_r;
  assign out_ch.overloaded   = out_over_r;

endmodule

@@ hdl/dllm_muldiv.sv @@
// Shift-add multiplier and restoring divider around one adder, one bit per cycle.
module dllm_muldiv import dllm_pkg::*; #(
  parameter int ACC_WIDTH = 48,
  localparam int PROD_W = ACC_WIDTH + LAT4_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  md_cmd_t              cmd,
  output md_sts_t              sts,
  input  logic [ACC_WIDTH-1:0] opnd,
  input  logic [LAT4_W-1:0]    mplier,
  input  logic [ACC_WIDTH-1:0] dividend,
  output logic [PROD_W-1:0]    result
);

  localparam int STEP_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0]    acc_r, acc_nxt;
  logic [ACC_WIDTH-1:0] rem_r, rem_nxt;
  logic [ACC_WIDTH-1:0] opnd_r, opnd_nxt;
  logic [LAT4_W-1:0]    mpl_r, mpl_nxt;
  logic [STEP_W-1:0]    cnt_r, cnt_nxt;
  md_op_t               op_r, op_nxt;
  logic                 done_r, done_nxt;

  logic [ACC_WIDTH:0]   rem_sh;
  logic [PROD_W-1:0]    add_a, add_b, sum;
  logic                 add_cin;
  logic                 ge;

  // the one adder: accumulate for mul, trial subtract for div
  always_comb begin
    rem_sh = {rem_r, acc_r[PROD_W-1]};
    if (op_r == MD_MUL) begin
      add_a   = {acc_r[PROD_W-2:0], 1'b0};
      add_b   = mpl_r[LAT4_W-1] ? PROD_W'(opnd_r) : '0;
      add_cin = 1'b0;
    end else begin
      add_a   = PROD_W'(rem_sh);
      add_b   = ~PROD_W'(opnd_r);
      add_cin = 1'b1;
    end
    sum = add_a + add_b + PROD_W'(add_cin);
    ge  = ~sum[PROD_W-1];
  end

  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    opnd_nxt = opnd_r;
    mpl_nxt  = mpl_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      op_nxt   = cmd.op;
      opnd_nxt = opnd;
      rem_nxt  = '0;
      case (cmd.op)
        MD_MUL: begin
          acc_nxt = '0;
          mpl_nxt = mplier;
          cnt_nxt = STEP_W'(LAT4_W);
        end
        MD_DIV_WIDE: begin
          cnt_nxt = STEP_W'(PROD_W);
        end
        MD_DIV_ACC: begin
          // left-align; low bits fill with quotient
          acc_nxt = {dividend, {LAT4_W{1'b0}}};
          cnt_nxt = STEP_W'(ACC_WIDTH);
        end
        default: begin
          cnt_nxt = '0;
        end
      endcase
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - STEP_W'(1);
      done_nxt = (cnt_r == STEP_W'(1));
      if (op_r == MD_MUL) begin
        acc_nxt = sum;
        mpl_nxt = {mpl_r[LAT4_W-2:0], 1'b0};
      end else begin
        acc_nxt = {acc_r[PROD_W-2:0], ge};
        rem_nxt = ge ? sum[ACC_WIDTH-1:0] : rem_sh[ACC_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      op_r   <= MD_MUL;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
      done_r <= done_nxt;
    end
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    opnd_r <= opnd_nxt;
    mpl_r  <= mpl_nxt;
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign result   = acc_r;

endmodule

@@ hdl/dllm_chk.sv @@
`include "decaying_load_latency_monitor_core_defines.svh"

module dllm_chk import dllm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] count_rate,
  input logic [OUT_W-1:0] avg_latency,
  input logic [OUT_W-1:0] peak_latency,
  input logic             overloaded
);

  // beats taken in but not yet delivered
  logic [1:0] pend_r, pend_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `DLLM_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({count_rate, avg_latency, peak_latency, overloaded}), "result changed while stalled")
  `DLLM_AST_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready stayed high after a beat")
  `DLLM_AST_SAME(a_no_phantom, out_valid, pend_r != 2'd0, "result without an item")
  `DLLM_AST_SAME(a_pend_bound, 1'b1, pend_r != 2'd3, "more than two items in flight")

endmodule

bind decaying_load_latency_monitor_core dllm_chk u_dllm_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .count_rate   (out_ch.count_rate),
  .avg_latency  (out_ch.avg_latency),
  .peak_latency (out_ch.peak_latency),
  .overloaded   (out_ch.overloaded)
);
